FILE: hdl/gpc_pkg.sv
// Shared types, constants and rounding helper for the gray8 compositor.
`default_nettype none

package gpc_pkg;

    // operation kinds carried on the input tuser
    typedef enum logic [1:0] {
        KIND_LUMA  = 2'd0,
        KIND_OVER  = 2'd1,
        KIND_COVER = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    // what the final stage does with a pixel
    typedef enum logic [1:0] {
        OP_DST   = 2'd0,
        OP_LUMA  = 2'd1,
        OP_BLEND = 2'd2
    } op_t;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned NUM_CH = 4;
    localparam int unsigned SUM_W  = 18;

    // BT.601 integer luma weights and rounding bias
    localparam logic [SUM_W-1:0] LUMA_R    = 18'd299;
    localparam logic [SUM_W-1:0] LUMA_G    = 18'd587;
    localparam logic [SUM_W-1:0] LUMA_B    = 18'd114;
    localparam logic [SUM_W-1:0] LUMA_BIAS = 18'd500;

    // floor(n / 1000) = (n * LUMA_RECIP) >> LUMA_SHIFT for n < 2^18
    localparam logic [36:0]  LUMA_RECIP = 37'd268436;
    localparam int unsigned  LUMA_SHIFT = 28;

    localparam logic [15:0] MUL_BIAS = 16'd128;
    localparam logic [7:0]  FULL     = 8'hff;
    localparam logic [7:0]  NONE     = 8'h00;

    // (a*b + 127) / 255 given t = a*b + 128, exact for 8-bit a and b
    function automatic logic [7:0] div255(input logic [15:0] t);
        logic [15:0] s;
        s = t + {8'd0, t[15:8]};
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/gray8_premultiplied_compositor_core.sv
// Top level: four-stage gray8 premultiplied source-over compositor.
// One pixel per cycle unless the output stalls; the coverage, luma and reciprocal
// multipliers each sit in their own register stage.
// Each stage advances on its own, so bubbles close up under output back-pressure.
// Reset (aresetn low, synchronous) clears all stage valid bits.
`default_nettype none

module gray8_premultiplied_compositor_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] src_color, [39:32] dst_gray, [47:40] coverage
    input  wire logic [47:0] s_axis_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] new_gray
    output logic [7:0]       m_axis_tdata
);
    import gpc_pkg::*;

    logic adv1, adv2, adv3, adv4;

    // stage 1: coverage products
    logic        v1_reg;
    logic [15:0] prod1_reg [NUM_CH];
    logic [15:0] prod1_next [NUM_CH];
    logic [31:0] color1_reg;
    logic [7:0]  dst1_reg;
    kind_t       kind1_reg;
    logic        cov_zero1_reg;
    logic        scale1_reg;

    // stage 2: luma sum and destination product
    logic        v2_reg;
    op_t         op2_reg, op2_next;
    logic [SUM_W-1:0] sum2_reg, sum2_next;
    logic [15:0] dprod2_reg, dprod2_next;
    logic [7:0]  dst2_reg;

    // stage 3: divided luma and scaled destination
    logic        v3_reg;
    op_t         op3_reg;
    logic [7:0]  luma3_reg, luma3_next;
    logic [7:0]  dmul3_reg;
    logic [7:0]  dst3_reg;

    // stage 4: output
    logic        v4_reg;
    logic [7:0]  out4_reg, out4_next;

    logic [31:0] color_in;
    logic [7:0]  dst_in, cov_in;
    logic [7:0]  eff_ch [NUM_CH];
    logic [7:0]  eff_alpha;
    logic [36:0] recip_prod;
    logic [8:0]  blend_sum;

    assign color_in = s_axis_tdata[31:0];
    assign dst_in   = s_axis_tdata[39:32];
    assign cov_in   = s_axis_tdata[47:40];

    assign adv4 = !v4_reg || m_axis_tready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_axis_tready = adv1;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            prod1_next[i] = {8'd0, color_in[i*CH_W +: CH_W]} * {8'd0, cov_in} + MUL_BIAS;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            eff_ch[i] = scale1_reg ? div255(prod1_reg[i]) : color1_reg[i*CH_W +: CH_W];
        end
        eff_alpha = eff_ch[3];

        sum2_next = LUMA_R * {10'd0, eff_ch[2]} + LUMA_G * {10'd0, eff_ch[1]}
                  + LUMA_B * {10'd0, eff_ch[0]} + LUMA_BIAS;
        dprod2_next = {8'd0, dst1_reg} * {8'd0, FULL - eff_alpha} + MUL_BIAS;

        case (kind1_reg) inside
            KIND_LUMA: op2_next = OP_LUMA;
            KIND_OVER, KIND_COVER: begin
                if (kind1_reg == KIND_COVER && cov_zero1_reg) begin
                    op2_next = OP_DST;
                end else if (eff_alpha == NONE) begin
                    op2_next = OP_DST;
                end else if (eff_alpha == FULL) begin
                    op2_next = OP_LUMA;
                end else begin
                    op2_next = OP_BLEND;
                end
            end
            default:   op2_next = OP_DST;
        endcase
    end

    assign recip_prod = {19'd0, sum2_reg} * LUMA_RECIP;
    assign luma3_next = recip_prod[LUMA_SHIFT +: 8];

    assign blend_sum = {1'b0, luma3_reg} + {1'b0, dmul3_reg};

    always_comb begin
        case (op3_reg)
            OP_LUMA:  out4_next = luma3_reg;
            OP_BLEND: out4_next = blend_sum[8] ? FULL : blend_sum[7:0];
            default:  out4_next = dst3_reg;
        endcase
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_axis_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // payload: hold while a stage is full and the next stage cannot take it
    always_ff @(posedge aclk) begin
        if (adv1) begin
            prod1_reg     <= prod1_next;
            color1_reg    <= color_in;
            dst1_reg      <= dst_in;
            kind1_reg     <= kind_t'(s_axis_tuser);
            cov_zero1_reg <= (cov_in == NONE);
            scale1_reg    <= (kind_t'(s_axis_tuser) == KIND_COVER)
                             && (cov_in != NONE) && (cov_in != FULL);
        end
        if (adv2) begin
            op2_reg    <= op2_next;
            sum2_reg   <= sum2_next;
            dprod2_reg <= dprod2_next;
            dst2_reg   <= dst1_reg;
        end
        if (adv3) begin
            op3_reg   <= op2_reg;
            luma3_reg <= luma3_next;
            dmul3_reg <= div255(dprod2_reg);
            dst3_reg  <= dst2_reg;
        end
        if (adv4) begin
            out4_reg <= out4_next;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = out4_reg;

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && v4_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while every stage is full and stalled");

    // a non-black destination under a partial alpha always leaves a product
    a_blend_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && op2_reg == OP_BLEND && dst2_reg != NONE) |-> (dprod2_reg != 16'd128))
        else $error("blend selected with alpha of full scale");

    a_mid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !adv3) |=> (v2_reg && $stable(sum2_reg) && $stable(op2_reg)))
        else $error("stage two changed while stalled");

endmodule

`default_nettype wire
